// File: rtl/ptwhm_pkg.sv
// ----------------------------------------------------------------------------
// ptwhm_pkg
// Shared types and constants of the per-channel time-window hit merger.
// ----------------------------------------------------------------------------
package ptwhm_pkg;

    localparam int TIME_W     = 32;
    localparam int ENERGY_W   = 32;
    localparam int DEP_E_W    = 24;
    localparam int COUNT_W    = 16;
    localparam int TRACK_W    = 16;
    localparam int PART_W     = 32;
    localparam int CH_IN_W    = 8;
    localparam int SLOT_OUT_W = 10;

    localparam logic [TIME_W-1:0]   TIME_WINDOW_RESET = 32'd1000;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX        = '1;
    localparam logic [COUNT_W-1:0]  COUNT_MAX         = '1;

    localparam logic KIND_DEPOSIT = 1'b0;
    localparam logic KIND_EVENT   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHAN,
        ST_HIT
    } state_t;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clear_all;
    } chan_ctl_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } hit_ctl_t;

endpackage

// File: rtl/per_channel_time_window_hit_merger.sv
// ----------------------------------------------------------------------------
// per_channel_time_window_hit_merger
// Merges energy deposits into per-channel hits within a time window.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An event-start
// request, a deposit of zero energy and a deposit on a channel beyond the
// channel count take one cycle and give no result. A deposit that opens a
// new hit or finds the store full keeps busy high for one cycle, and one
// that merges into an open hit keeps it high for two: the channel store is
// read first, then the hit store is read, updated and written back. The
// result is shown for exactly one cycle with result_valid, in the cycle
// after busy falls, so a new request may be taken in that same cycle. The
// receiver cannot stall the block. The window register is written through
// cfg_valid and cfg_ready, which is high whenever the block is idle.
// Reset clears every open mark, empties the hit store and sets the window
// to 1000 ps; the memories need no clearing pass.
// ----------------------------------------------------------------------------
module per_channel_time_window_hit_merger #(
    parameter int NUM_CHANNELS = 256,
    parameter int MAX_HITS     = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             kind,
    input  logic [ptwhm_pkg::CH_IN_W-1:0]    channel,
    input  logic [ptwhm_pkg::TIME_W-1:0]     deposit_time,
    input  logic [ptwhm_pkg::DEP_E_W-1:0]    deposit_energy,
    input  logic [ptwhm_pkg::TRACK_W-1:0]    track_number,
    input  logic signed [ptwhm_pkg::PART_W-1:0] particle_code,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ptwhm_pkg::TIME_W-1:0]     cfg_data,
    output logic                             result_valid,
    output logic [ptwhm_pkg::SLOT_OUT_W-1:0] hit_slot,
    output logic                             opened,
    output logic [ptwhm_pkg::ENERGY_W-1:0]   energy_total,
    output logic [ptwhm_pkg::COUNT_W-1:0]    interaction_count,
    output logic                             store_full
);
    import ptwhm_pkg::*;

    localparam int CH_AW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int HIT_AW = $clog2(MAX_HITS);
    localparam int HIT_CW = $clog2(MAX_HITS + 1);
    localparam logic [HIT_CW-1:0] HIT_LIMIT = HIT_CW'(MAX_HITS);

    state_t state_reg, state_next;

    logic [TIME_W-1:0]   window_reg;
    logic [HIT_CW-1:0]   hit_count_reg, hit_count_next;
    logic [CH_AW-1:0]    ch_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [DEP_E_W-1:0]  energy_reg;
    logic [TRACK_W-1:0]  track_reg;
    logic [PART_W-1:0]   part_reg;
    logic [HIT_AW-1:0]   slot_reg, slot_next;

    logic                  res_valid_reg, res_valid_next;
    logic [SLOT_OUT_W-1:0] res_slot_reg, res_slot_next;
    logic                  res_opened_reg, res_opened_next;
    logic [ENERGY_W-1:0]   res_energy_reg, res_energy_next;
    logic [COUNT_W-1:0]    res_count_reg, res_count_next;
    logic                  res_full_reg, res_full_next;

    logic accept;
    logic deposit_ok;
    logic merge;
    logic store_is_full;
    logic [TIME_W-1:0] diff;
    logic [ENERGY_W:0] sum;
    logic [ENERGY_W-1:0] sum_sat;
    logic [COUNT_W-1:0] count_sat;

    chan_ctl_t           chan_ctl;
    logic [CH_AW-1:0]    chan_addr;
    logic                chan_rd_open;
    logic [TIME_W-1:0]   chan_rd_time;
    logic [HIT_AW-1:0]   chan_rd_slot;

    hit_ctl_t            hit_ctl;
    logic [HIT_AW-1:0]   hit_addr;
    logic [ENERGY_W-1:0] hit_wr_energy;
    logic [COUNT_W-1:0]  hit_wr_count;
    logic [TRACK_W-1:0]  hit_wr_track;
    logic [PART_W-1:0]   hit_wr_part;
    logic [ENERGY_W-1:0] hit_rd_energy;
    logic [COUNT_W-1:0]  hit_rd_count;
    logic [TRACK_W-1:0]  hit_rd_track;
    logic [PART_W-1:0]   hit_rd_part;

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = !busy;
    assign accept     = start && !busy;
    assign deposit_ok = (kind == KIND_DEPOSIT) && (deposit_energy != '0)
                        && (32'(channel) < NUM_CHANNELS);

    assign diff = (time_reg >= chan_rd_time) ? (time_reg - chan_rd_time)
                                             : (chan_rd_time - time_reg);
    assign merge         = chan_rd_open && (diff < window_reg);
    assign store_is_full = (hit_count_reg >= HIT_LIMIT);

    assign sum       = {1'b0, hit_rd_energy} + (ENERGY_W + 1)'(energy_reg);
    assign sum_sat   = sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];
    assign count_sat = (hit_rd_count == COUNT_MAX) ? COUNT_MAX
                                                   : hit_rd_count + COUNT_W'(1);

    ptwhm_chan_mem #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CH_AW        (CH_AW),
        .SLOT_W       (HIT_AW)
    ) u_chan_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (chan_ctl),
        .addr    (chan_addr),
        .wr_time (time_reg),
        .wr_slot (hit_count_reg[HIT_AW-1:0]),
        .rd_open (chan_rd_open),
        .rd_time (chan_rd_time),
        .rd_slot (chan_rd_slot)
    );

    ptwhm_hit_mem #(
        .MAX_HITS (MAX_HITS),
        .HIT_AW   (HIT_AW)
    ) u_hit_mem (
        .clk         (clk),
        .ctl         (hit_ctl),
        .addr        (hit_addr),
        .wr_energy   (hit_wr_energy),
        .wr_count    (hit_wr_count),
        .wr_track    (hit_wr_track),
        .wr_particle (hit_wr_part),
        .rd_energy   (hit_rd_energy),
        .rd_count    (hit_rd_count),
        .rd_track    (hit_rd_track),
        .rd_particle (hit_rd_part)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && deposit_ok)
                begin
                    state_next = ST_CHAN;
                end
            end
            ST_CHAN:
            begin
                state_next = merge ? ST_HIT : ST_IDLE;
            end
            ST_HIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        chan_ctl        = '0;
        chan_addr       = ch_reg;
        hit_ctl         = '0;
        hit_addr        = hit_count_reg[HIT_AW-1:0];
        hit_wr_energy   = ENERGY_W'(energy_reg);
        hit_wr_count    = COUNT_W'(1);
        hit_wr_track    = track_reg;
        hit_wr_part     = part_reg;
        hit_count_next  = hit_count_reg;
        slot_next       = slot_reg;
        res_valid_next  = 1'b0;
        res_slot_next   = res_slot_reg;
        res_opened_next = res_opened_reg;
        res_energy_next = res_energy_reg;
        res_count_next  = res_count_reg;
        res_full_next   = res_full_reg;
        case (state_reg)
            ST_IDLE:
            begin
                chan_addr          = CH_AW'(channel);
                chan_ctl.rd        = accept && deposit_ok;
                chan_ctl.clear_all = accept && (kind == KIND_EVENT);
                if (accept && (kind == KIND_EVENT))
                begin
                    hit_count_next = '0;
                end
            end
            ST_CHAN:
            begin
                res_valid_next = !merge;
                if (merge)
                begin
                    hit_ctl.rd = 1'b1;
                    hit_addr   = chan_rd_slot;
                    slot_next  = chan_rd_slot;
                end
                else if (store_is_full)
                begin
                    res_slot_next   = '0;
                    res_opened_next = 1'b0;
                    res_energy_next = '0;
                    res_count_next  = '0;
                    res_full_next   = 1'b1;
                end
                else
                begin
                    hit_ctl.wr      = 1'b1;
                    chan_ctl.wr     = 1'b1;
                    hit_count_next  = hit_count_reg + HIT_CW'(1);
                    res_slot_next   = SLOT_OUT_W'(hit_count_reg[HIT_AW-1:0]);
                    res_opened_next = 1'b1;
                    res_energy_next = ENERGY_W'(energy_reg);
                    res_count_next  = COUNT_W'(1);
                    res_full_next   = 1'b0;
                end
            end
            ST_HIT:
            begin
                hit_ctl.wr      = 1'b1;
                hit_addr        = slot_reg;
                hit_wr_energy   = sum_sat;
                hit_wr_count    = count_sat;
                hit_wr_track    = hit_rd_track;
                hit_wr_part     = hit_rd_part;
                res_valid_next  = 1'b1;
                res_slot_next   = SLOT_OUT_W'(slot_reg);
                res_opened_next = 1'b0;
                res_energy_next = sum_sat;
                res_count_next  = count_sat;
                res_full_next   = 1'b0;
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= TIME_WINDOW_RESET;
            hit_count_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_count_reg <= hit_count_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                window_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg     <= CH_AW'(channel);
            time_reg   <= deposit_time;
            energy_reg <= deposit_energy;
            track_reg  <= track_number;
            part_reg   <= particle_code;
        end
        slot_reg       <= slot_next;
        res_slot_reg   <= res_slot_next;
        res_opened_reg <= res_opened_next;
        res_energy_reg <= res_energy_next;
        res_count_reg  <= res_count_next;
        res_full_reg   <= res_full_next;
    end

    assign result_valid      = res_valid_reg;
    assign hit_slot          = res_slot_reg;
    assign opened            = res_opened_reg;
    assign energy_total      = res_energy_reg;
    assign interaction_count = res_count_reg;
    assign store_full        = res_full_reg;

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $past(state_reg != ST_IDLE))
        else $error("Result strobe without a request in progress.");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        hit_count_reg <= HIT_LIMIT)
        else $error("Hit count beyond the store size.");

    a_hit_after_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HIT) |-> $past(state_reg == ST_CHAN))
        else $error("Hit update without a preceding channel lookup.");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_full_reg) |-> (hit_count_reg == HIT_LIMIT))
        else $error("Store-full result while free slots remain.");

endmodule

// File: rtl/ptwhm_chan_mem.sv
// ----------------------------------------------------------------------------
// ptwhm_chan_mem
// Channel store: opening time and slot of each channel's open hit in a
// synchronous memory, with open marks in flip-flops that clear at once.
// ----------------------------------------------------------------------------
module ptwhm_chan_mem #(
    parameter int NUM_CHANNELS = 256,
    parameter int CH_AW        = 8,
    parameter int SLOT_W       = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ptwhm_pkg::chan_ctl_t        ctl,
    input  logic [CH_AW-1:0]            addr,
    input  logic [ptwhm_pkg::TIME_W-1:0] wr_time,
    input  logic [SLOT_W-1:0]           wr_slot,
    output logic                        rd_open,
    output logic [ptwhm_pkg::TIME_W-1:0] rd_time,
    output logic [SLOT_W-1:0]           rd_slot
);
    import ptwhm_pkg::*;

    localparam int WORD_W = TIME_W + SLOT_W;

    logic [WORD_W-1:0]       mem [NUM_CHANNELS];
    logic [WORD_W-1:0]       rd_word_reg;
    logic [NUM_CHANNELS-1:0] open_reg;
    logic                    rd_open_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= {wr_time, wr_slot};
        end
        if (ctl.rd)
        begin
            rd_word_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg    <= '0;
            rd_open_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear_all)
            begin
                open_reg <= '0;
            end
            else if (ctl.wr)
            begin
                open_reg[addr] <= 1'b1;
            end
            if (ctl.rd)
            begin
                rd_open_reg <= open_reg[addr];
            end
        end
    end

    assign rd_open = rd_open_reg;
    assign rd_time = rd_word_reg[WORD_W-1:SLOT_W];
    assign rd_slot = rd_word_reg[SLOT_W-1:0];

endmodule

// File: rtl/ptwhm_hit_mem.sv
// ----------------------------------------------------------------------------
// ptwhm_hit_mem
// Hit store: energy, interaction count, track and particle code of every
// hit in one synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module ptwhm_hit_mem #(
    parameter int MAX_HITS = 1024,
    parameter int HIT_AW   = 10
) (
    input  logic                          clk,
    input  ptwhm_pkg::hit_ctl_t           ctl,
    input  logic [HIT_AW-1:0]             addr,
    input  logic [ptwhm_pkg::ENERGY_W-1:0] wr_energy,
    input  logic [ptwhm_pkg::COUNT_W-1:0]  wr_count,
    input  logic [ptwhm_pkg::TRACK_W-1:0]  wr_track,
    input  logic [ptwhm_pkg::PART_W-1:0]   wr_particle,
    output logic [ptwhm_pkg::ENERGY_W-1:0] rd_energy,
    output logic [ptwhm_pkg::COUNT_W-1:0]  rd_count,
    output logic [ptwhm_pkg::TRACK_W-1:0]  rd_track,
    output logic [ptwhm_pkg::PART_W-1:0]   rd_particle
);
    import ptwhm_pkg::*;

    localparam int WORD_W = PART_W + TRACK_W + COUNT_W + ENERGY_W;

    logic [WORD_W-1:0] mem [MAX_HITS];
    logic [WORD_W-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= {wr_particle, wr_track, wr_count, wr_energy};
        end
        if (ctl.rd)
        begin
            rd_word_reg <= mem[addr];
        end
    end

    assign {rd_particle, rd_track, rd_count, rd_energy} = rd_word_reg;

endmodule
